@@ rtl/core/run_step_clock_tracer_defines.svh @@
// assertion macros shared by the clock tracer rtl
// depends on nothing; the asserting modules must have clk and arst_n in scope
`ifndef RUN_STEP_CLOCK_TRACER_DEFINES_SVH
`define RUN_STEP_CLOCK_TRACER_DEFINES_SVH
`ifndef SYNTHESIS
`define RSCT_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("rsct assertion failed");
`define RSCT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsct assertion failed");
`else
`define RSCT_ASSERT(lbl, cond)
`define RSCT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/rsct_pkg.sv @@
// types, constants and helpers for the run/step clock tracer
// depends on nothing
`default_nettype none
package rsct_pkg;
	localparam int unsigned AddrW  = 16;
	localparam int unsigned DataW  = 8;
	localparam int unsigned SpeedW = 8;
	localparam int unsigned DebW   = 8;
	localparam int unsigned PulseW = 4;
	localparam int unsigned CountW = 11;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 8;
	localparam int unsigned SpeedShift = 6;

	localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_TICKS    = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_MIN_PULSE_TICKS   = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_HALT_ACTIVE_LEVEL = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_STEP_ACTIVE_LEVEL = 2'd3;

	localparam logic [DebW-1:0]   DEBOUNCE_RESET  = 8'd20;
	localparam logic [PulseW-1:0] MIN_PULSE_RESET = 4'd1;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_HIGH = 4'b0010,
		PH_LOW  = 4'b0100,
		PH_WAIT = 4'b1000
	} phase_t;

	typedef struct packed {
		logic stable;
		logic stable_d;
		logic accept;
	} deb_stat_t;

	function automatic logic [DebW-1:0] eff_debounce(input logic [DebW-1:0] v);
		return (v == '0) ? DebW'(1) : v;
	endfunction

	function automatic logic [PulseW-1:0] eff_pulse(input logic [PulseW-1:0] v);
		return (v == '0) ? PulseW'(1) : v;
	endfunction
endpackage
`default_nettype wire

@@ rtl/core/run_step_clock_tracer.sv @@
// Run/step clock generator and bus tracer. One item is one millisecond tick; the block
// accepts one item per clock cycle while the result side keeps up, and returns exactly
// one result per item, through the input register and then the result register. The
// whole state update for a tick, including the 8x8 speed square for the wait length, is
// a single combinational pass between those registers, so throughput is one item per
// cycle whenever the result side keeps up. Configuration writes are taken at any time
// (cfg_ready is always high) and should only be made while no item is in flight.
// depends on rsct_pkg, rsct_debounce, rsct_pulse and run_step_clock_tracer_defines.svh
`default_nettype none
`include "run_step_clock_tracer_defines.svh"
module run_step_clock_tracer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          halt_level,
	input  wire logic                          step_level,
	input  wire logic [rsct_pkg::SpeedW-1:0]   speed,
	input  wire logic [rsct_pkg::AddrW-1:0]    bus_addr,
	input  wire logic [rsct_pkg::DataW-1:0]    bus_data,
	input  wire logic                          bus_rw,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               clock_out,
	output logic                               trace_valid,
	output logic [rsct_pkg::AddrW-1:0]         trace_addr,
	output logic [rsct_pkg::DataW-1:0]         trace_data,
	output logic                               trace_rw,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [rsct_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [rsct_pkg::CfgDataW-1:0] cfg_data
);
	import rsct_pkg::*;

	// configuration
	logic [DebW-1:0]   deb_ticks_q;
	logic [PulseW-1:0] pulse_ticks_q;
	logic              halt_active_q;
	logic              step_active_q;

	// input register
	logic              valid_s1;
	logic              halt_s1;
	logic              step_s1;
	logic [SpeedW-1:0] speed_s1;
	logic [AddrW-1:0]  addr_s1;
	logic [DataW-1:0]  data_s1;
	logic              rw_s1;

	logic      advance;
	logic      free_run;
	logic      clock_level;
	logic      rise;
	deb_stat_t halt_stat;
	deb_stat_t step_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_ticks_q   <= DEBOUNCE_RESET;
			pulse_ticks_q <= MIN_PULSE_RESET;
			halt_active_q <= 1'b0;
			step_active_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DEBOUNCE_TICKS:    deb_ticks_q   <= cfg_data[DebW-1:0];
				CFG_MIN_PULSE_TICKS:   pulse_ticks_q <= cfg_data[PulseW-1:0];
				CFG_HALT_ACTIVE_LEVEL: halt_active_q <= cfg_data[0];
				CFG_STEP_ACTIVE_LEVEL: step_active_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			halt_s1  <= halt_level;
			step_s1  <= step_level;
			speed_s1 <= speed;
			addr_s1  <= bus_addr;
			data_s1  <= bus_data;
			rw_s1    <= bus_rw;
		end
	end

	rsct_debounce u_halt_deb (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.sample    (halt_s1),
		.deb_ticks (eff_debounce(deb_ticks_q)),
		.stat      (halt_stat)
	);

	assign free_run = (halt_stat.stable_d == halt_active_q);

	// step pin is frozen while free-running
	rsct_debounce u_step_deb (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance && !free_run),
		.sample    (step_s1),
		.deb_ticks (eff_debounce(deb_ticks_q)),
		.stat      (step_stat)
	);

	rsct_pulse u_pulse (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.free_run    (free_run),
		.step_stat   (step_stat),
		.step_active (step_active_q),
		.pulse_ticks (eff_pulse(pulse_ticks_q)),
		.speed       (speed_s1),
		.clock_level (clock_level),
		.rise        (rise)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			clock_out   <= clock_level;
			trace_valid <= rise;
			trace_addr  <= rise ? addr_s1 : '0;
			trace_data  <= rise ? data_s1 : '0;
			trace_rw    <= rise & rw_s1;
		end
	end

	`RSCT_ASSERT(a_trace_needs_clock, !out_valid || !trace_valid || clock_out)
	`RSCT_ASSERT(a_trace_zero_idle,
		!out_valid || trace_valid || (trace_addr == '0 && trace_data == '0 && !trace_rw))
	`RSCT_ASSERT(a_stall_reason, in_ready || (valid_s1 && out_valid && !out_ready))
endmodule
`default_nettype wire

@@ rtl/core/rsct_debounce.sv @@
// pin debouncer: timer plus accepted level, changes confirmed after the debounce time
// depends on rsct_pkg
`default_nettype none
module rsct_debounce (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      sample,
	input  wire logic [rsct_pkg::DebW-1:0] deb_ticks,
	output rsct_pkg::deb_stat_t            stat
);
	import rsct_pkg::*;

	logic [DebW-1:0] timer_q, timer_d;
	logic            stable_q;
	logic            accept;

	// no change is reported while the pin is not being sampled
	always_comb begin
		timer_d = timer_q;
		accept  = 1'b0;
		if (timer_q != '0) begin
			timer_d = timer_q - DebW'(1);
			accept  = en && (timer_q == DebW'(1)) && (sample != stable_q);
		end else if (sample != stable_q) begin
			timer_d = deb_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q  <= '0;
			stable_q <= 1'b0;
		end else if (en) begin
			timer_q <= timer_d;
			if (accept) stable_q <= sample;
		end
	end

	assign stat.stable   = stable_q;
	assign stat.stable_d = accept ? sample : stable_q;
	assign stat.accept   = accept;
endmodule
`default_nettype wire

@@ rtl/core/rsct_pulse.sv @@
// pulse sequencer: high, low and wait phases, step press edge detection
// depends on rsct_pkg and run_step_clock_tracer_defines.svh
`default_nettype none
`include "run_step_clock_tracer_defines.svh"
module rsct_pulse (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        free_run,
	input  wire rsct_pkg::deb_stat_t         step_stat,
	input  wire logic                        step_active,
	input  wire logic [rsct_pkg::PulseW-1:0] pulse_ticks,
	input  wire logic [rsct_pkg::SpeedW-1:0] speed,
	output logic                             clock_level,
	output logic                             rise
);
	import rsct_pkg::*;

	phase_t            phase_q, phase_d;
	logic [CountW-1:0] count_q, count_d;
	logic              prev_q, prev_d;
	logic [2*SpeedW-1:0] speed_sq;
	logic [CountW-1:0] pulse_len;
	logic [CountW-1:0] wait_len;

	assign speed_sq  = (2*SpeedW)'(speed) * (2*SpeedW)'(speed);
	assign pulse_len = CountW'(pulse_ticks) - CountW'(1);
	assign wait_len  = CountW'(speed_sq >> SpeedShift) + CountW'(pulse_ticks) - CountW'(1);

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		prev_d  = prev_q;
		rise    = 1'b0;
		if (step_stat.accept) prev_d = step_stat.stable;
		if (phase_q != PH_IDLE && count_q != '0) begin
			count_d = count_q - CountW'(1);
		end else begin
			case (phase_q)
				PH_HIGH: begin
					phase_d = PH_LOW;
					count_d = pulse_len;
				end
				PH_LOW: begin
					if (free_run) begin
						phase_d = PH_WAIT;
						count_d = wait_len;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_WAIT: phase_d = PH_IDLE;
				default: ;
			endcase
		end
		if (phase_d == PH_IDLE) begin
			if (free_run) begin
				rise = 1'b1;
			end else if (prev_d != step_active && step_stat.stable_d == step_active) begin
				rise   = 1'b1;
				prev_d = step_stat.stable_d;
			end
			if (rise) begin
				phase_d = PH_HIGH;
				count_d = pulse_len;
			end
		end
	end

	assign clock_level = (phase_d == PH_HIGH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			prev_q  <= 1'b1;
		end else if (en) begin
			phase_q <= phase_d;
			count_q <= count_d;
			prev_q  <= prev_d;
		end
	end

	`RSCT_ASSERT(a_idle_count_zero, (phase_q != PH_IDLE) || (count_q == '0))
	`RSCT_ASSERT_NEXT(a_rise_enters_high, en && rise, phase_q == PH_HIGH)
endmodule
`default_nettype wire

@@ tb/sv/tb_run_step_clock_tracer.sv @@
// self-checking testbench for run_step_clock_tracer: directed tick table, then random phases
// with debounced pin patterns, random idling and backpressure, mostly checked against a tick model
// depends on rsct_pkg and the run_step_clock_tracer rtl
`timescale 1ns / 1ps
module tb_run_step_clock_tracer;
	import rsct_pkg::*;

	localparam int RANDOM_ITEMS = 1200;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = 6;
	localparam int CYCLE_LIMIT  = 500000;

	typedef struct packed {
		logic             halt;
		logic             step;
		logic [SpeedW-1:0] speed;
		logic [AddrW-1:0] addr;
		logic [DataW-1:0] data;
		logic             rw;
	} tick_t;

	typedef struct packed {
		logic             clock_out;
		logic             trace_valid;
		logic [AddrW-1:0] addr;
		logic [DataW-1:0] data;
		logic             rw;
	} result_t;

	typedef struct packed {
		logic                is_reg;
		logic [CfgIdxW-1:0]  idx;
		logic [CfgDataW-1:0] val;
		tick_t               t;
		logic                typed;
		result_t             r;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic halt_level = 1'b0;
	logic step_level = 1'b0;
	logic [SpeedW-1:0] speed = '0;
	logic [AddrW-1:0] bus_addr = '0;
	logic [DataW-1:0] bus_data = '0;
	logic bus_rw = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic clock_out;
	logic trace_valid;
	logic [AddrW-1:0] trace_addr;
	logic [DataW-1:0] trace_data;
	logic trace_rw;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	run_step_clock_tracer u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.halt_level(halt_level), .step_level(step_level), .speed(speed),
		.bus_addr(bus_addr), .bus_data(bus_data), .bus_rw(bus_rw),
		.out_valid(out_valid), .out_ready(out_ready),
		.clock_out(clock_out), .trace_valid(trace_valid),
		.trace_addr(trace_addr), .trace_data(trace_data), .trace_rw(trace_rw),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// tick model state and its copy of the registers
	logic [DebW-1:0]   m_deb = DEBOUNCE_RESET;
	logic [PulseW-1:0] m_pulse = MIN_PULSE_RESET;
	logic              m_halt_lvl = 1'b0;
	logic              m_step_lvl = 1'b0;
	phase_t            m_phase = PH_IDLE;
	logic [CountW-1:0] m_left = '0;
	logic              m_halt_acc = 1'b0;
	logic [DebW-1:0]   m_halt_tmr = '0;
	logic              m_step_acc = 1'b0;
	logic              m_step_prior = 1'b1;
	logic [DebW-1:0]   m_step_tmr = '0;

	result_t clock_trace_due[$];
	row_t    tick_table[$];
	int      mismatches = 0;
	int      cycles = 0;
	bit      hold_req = 0;
	bit      rx_calm = 0;
	int      rx_stall = 0;
	result_t got_r;
	result_t want_r;

	task automatic settle_pin(input logic sample, input logic acc, inout logic [DebW-1:0] tmr,
			output logic take);
		take = 1'b0;
		if (tmr != 0) begin
			tmr = tmr - 1'b1;
			take = (tmr == 0) && (sample != acc);
		end else if (sample != acc) begin
			tmr = (m_deb == 0) ? DebW'(1) : m_deb;
		end
	endtask

	task automatic advance_tracer(input tick_t t, output result_t r);
		logic take;
		logic free_run;
		logic rise;
		int   pw;
		int   sq;
		pw = (m_pulse == 0) ? 1 : int'(m_pulse);
		settle_pin(t.halt, m_halt_acc, m_halt_tmr, take);
		if (take)
			m_halt_acc = t.halt;
		free_run = (m_halt_acc == m_halt_lvl);
		if (!free_run) begin
			settle_pin(t.step, m_step_acc, m_step_tmr, take);
			if (take) begin
				m_step_prior = m_step_acc;
				m_step_acc = t.step;
			end
		end
		if (m_phase != PH_IDLE && m_left != 0) begin
			m_left = m_left - 1'b1;
		end else if (m_phase == PH_HIGH) begin
			m_phase = PH_LOW;
			m_left = CountW'(pw - 1);
		end else if (m_phase == PH_LOW) begin
			if (free_run) begin
				sq = int'(t.speed) * int'(t.speed);
				m_phase = PH_WAIT;
				m_left = CountW'((sq >> SpeedShift) + pw - 1);
			end else begin
				m_phase = PH_IDLE;
			end
		end else if (m_phase == PH_WAIT) begin
			m_phase = PH_IDLE;
		end
		rise = 1'b0;
		if (m_phase == PH_IDLE) begin
			if (free_run) begin
				rise = 1'b1;
			end else if (m_step_prior != m_step_lvl && m_step_acc == m_step_lvl) begin
				rise = 1'b1;
				m_step_prior = m_step_acc;
			end
			if (rise) begin
				m_phase = PH_HIGH;
				m_left = CountW'(pw - 1);
			end
		end
		r.clock_out = (m_phase == PH_HIGH);
		r.trace_valid = rise;
		r.addr = rise ? t.addr : '0;
		r.data = rise ? t.data : '0;
		r.rw = rise ? t.rw : 1'b0;
	endtask

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic tick_t tk(input logic h, input logic s, input logic [SpeedW-1:0] spd,
			input logic [AddrW-1:0] a, input logic [DataW-1:0] d, input logic rw);
		tk = {h, s, spd, a, d, rw};
	endfunction

	task automatic log_mismatch(input string what, input int got_v, input int want_v);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t mismatch %s: got %0h want %0h", $time, what, got_v, want_v);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_DEBOUNCE_TICKS: m_deb = val;
			CFG_MIN_PULSE_TICKS: m_pulse = val[PulseW-1:0];
			CFG_HALT_ACTIVE_LEVEL: m_halt_lvl = val[0];
			default: m_step_lvl = val[0];
		endcase
	endtask

	task automatic send_tick(input tick_t t, input int gap, input logic typed, input result_t tr);
		result_t r;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		halt_level <= t.halt;
		step_level <= t.step;
		speed <= t.speed;
		bus_addr <= t.addr;
		bus_data <= t.data;
		bus_rw <= t.rw;
		do @(posedge clk); while (!in_ready);
		advance_tracer(t, r);
		clock_trace_due.push_back(typed ? tr : r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (clock_trace_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic put_tick(input tick_t t, input logic typed, input result_t r);
		tick_table.push_back({1'b0, CfgIdxW'(0), CfgDataW'(0), t, typed, r});
	endtask

	task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		tick_table.push_back({1'b1, idx, val, tick_t'(0), 1'b0, result_t'(0)});
	endtask

	// result side: random stalls plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (rx_stall != 0) begin
				rx_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!rx_calm && $urandom_range(0, 3) == 0)
					rx_stall = idle_len();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_r = {clock_out, trace_valid, trace_addr, trace_data, trace_rw};
			if (clock_trace_due.size() == 0) begin
				log_mismatch("unexpected item", int'(got_r), 0);
			end else begin
				want_r = clock_trace_due.pop_front();
				if (got_r.clock_out !== want_r.clock_out)
					log_mismatch("clock_out", got_r.clock_out, want_r.clock_out);
				if (got_r.trace_valid !== want_r.trace_valid)
					log_mismatch("trace_valid", got_r.trace_valid, want_r.trace_valid);
				if (got_r.addr !== want_r.addr)
					log_mismatch("trace_addr", got_r.addr, want_r.addr);
				if (got_r.data !== want_r.data)
					log_mismatch("trace_data", got_r.data, want_r.data);
				if (got_r.rw !== want_r.rw)
					log_mismatch("trace_rw", got_r.rw, want_r.rw);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_run_step_clock_tracer: FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		row_t    row;
		tick_t   t;
		logic    reg_open;
		logic    calm;
		logic    halt_want;
		logic    step_want;
		int      halt_left;
		int      step_left;
		int      p;
		int      n;
		int      len;
		int      deb;
		int      deb_eff;
		int      pulse;
		int      total;
		int      r;

		// free-run from reset: rise, low, zero wait, rise again
		put_tick(tk(0, 0, 8'h00, 16'hFFFF, 8'hFF, 1), 1, {1'b1, 1'b1, 16'hFFFF, 8'hFF, 1'b1});
		put_tick(tk(0, 0, 8'hFF, 16'h1234, 8'h5A, 0), 1, '0);
		put_tick(tk(0, 0, 8'h00, 16'h0000, 8'h00, 1), 1, '0);
		put_tick(tk(0, 0, 8'h50, 16'h0000, 8'h00, 0), 1, {1'b1, 1'b1, 16'h0000, 8'h00, 1'b0});
		put_tick(tk(0, 0, 8'h00, 16'hAAAA, 8'h55, 1), 1, '0);
		put_tick(tk(0, 0, 8'h08, 16'h5555, 8'hAA, 0), 0, '0);
		put_tick(tk(0, 0, 8'hFF, 16'h0001, 8'h80, 1), 0, '0);
		put_tick(tk(0, 0, 8'h00, 16'h8000, 8'h01, 1), 0, '0);
		// zero debounce and zero width, switch to step mode while a pulse runs
		put_reg(CFG_DEBOUNCE_TICKS, 8'd0);
		put_reg(CFG_MIN_PULSE_TICKS, 8'd0);
		put_reg(CFG_HALT_ACTIVE_LEVEL, 8'd1);
		put_reg(CFG_STEP_ACTIVE_LEVEL, 8'd1);
		put_tick(tk(0, 1, 8'h00, 16'h0F0F, 8'h3C, 1), 0, '0);
		put_tick(tk(0, 1, 8'h00, 16'hF0F0, 8'hC3, 1), 0, '0);
		put_tick(tk(0, 1, 8'h00, 16'h1111, 8'h11, 0), 0, '0);
		put_tick(tk(0, 0, 8'h00, 16'h2222, 8'h22, 1), 0, '0);
		put_tick(tk(0, 0, 8'h00, 16'h3333, 8'h33, 0), 0, '0);
		// single-tick bounce on step is rejected
		put_tick(tk(0, 1, 8'h00, 16'h4444, 8'h44, 1), 0, '0);
		put_tick(tk(0, 0, 8'h00, 16'h5555, 8'h55, 0), 0, '0);
		// halt becomes active, step timer holds during free-run
		put_tick(tk(1, 1, 8'h00, 16'h6666, 8'h66, 1), 0, '0);
		put_tick(tk(1, 0, 8'h00, 16'h7777, 8'h77, 0), 0, '0);
		put_tick(tk(1, 1, 8'hFF, 16'hFFFF, 8'hFF, 1), 0, '0);
		put_tick(tk(1, 0, 8'h03, 16'h9999, 8'h99, 0), 0, '0);
		put_tick(tk(1, 0, 8'h00, 16'hABCD, 8'hEF, 1), 0, '0);
		// widest pulse and longest debounce, back to step mode
		put_reg(CFG_DEBOUNCE_TICKS, 8'd255);
		put_reg(CFG_MIN_PULSE_TICKS, 8'd15);
		put_reg(CFG_HALT_ACTIVE_LEVEL, 8'd0);
		put_reg(CFG_STEP_ACTIVE_LEVEL, 8'd0);
		put_tick(tk(1, 1, 8'h00, 16'hFEDC, 8'hBA, 0), 0, '0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_open = 1'b0;
		foreach (tick_table[i]) begin
			row = tick_table[i];
			if (row.is_reg) begin
				if (!reg_open)
					drain();
				reg_open = 1'b1;
				write_reg(row.idx, row.val);
			end else begin
				if (reg_open)
					cfg_valid <= 1'b0;
				reg_open = 1'b0;
				send_tick(row.t, idle_len(), row.typed, row.r);
			end
		end
		drain();

		total = 0;
		halt_want = 1'b1;
		step_want = 1'b1;
		halt_left = 0;
		step_left = 0;
		for (p = 0; total < RANDOM_ITEMS; p++) begin
			if (p == 0)
				deb = 1;
			else if (p == 1)
				deb = 255;
			else if (p == 2)
				deb = 0;
			else if ($urandom_range(0, 4) == 0)
				deb = $urandom_range(13, 254);
			else
				deb = $urandom_range(1, 12);
			pulse = (p == 0) ? 15 : (p == 1) ? 1 : (p == 2) ? 0 : $urandom_range(1, 15);
			write_reg(CFG_DEBOUNCE_TICKS, CfgDataW'(deb));
			write_reg(CFG_MIN_PULSE_TICKS, CfgDataW'(pulse));
			write_reg(CFG_HALT_ACTIVE_LEVEL, (p < 2) ? CfgDataW'(p) : CfgDataW'($urandom_range(0, 1)));
			write_reg(CFG_STEP_ACTIVE_LEVEL, (p < 2) ? CfgDataW'(1 - p) : CfgDataW'($urandom_range(0, 1)));
			cfg_valid <= 1'b0;
			deb_eff = (deb == 0) ? 1 : deb;
			len = (deb_eff > 32) ? deb_eff + 60 + $urandom_range(0, deb_eff) : $urandom_range(60, 140);
			calm = (p % 3 == 2);
			rx_calm = calm;
			for (n = 0; n < len; n++) begin
				// pins held past the debounce time mostly, sometimes released too early
				if (halt_left == 0) begin
					halt_want = !halt_want;
					halt_left = deb_eff + $urandom_range(1, 3 * deb_eff + 30);
					if ($urandom_range(0, 5) == 0)
						halt_left = $urandom_range(1, deb_eff);
				end
				if (step_left == 0) begin
					step_want = !step_want;
					step_left = deb_eff + $urandom_range(1, deb_eff + 6);
					if ($urandom_range(0, 5) == 0)
						step_left = $urandom_range(1, deb_eff);
				end
				halt_left--;
				step_left--;
				t.halt = halt_want ^ ($urandom_range(0, 24) == 0);
				t.step = step_want ^ ($urandom_range(0, 19) == 0);
				r = $urandom_range(0, 19);
				if (r < 15)
					t.speed = $urandom_range(0, 40);
				else if (r < 19)
					t.speed = $urandom_range(0, 255);
				else
					t.speed = 8'hFF;
				t.addr = $urandom_range(0, 65535);
				t.data = $urandom_range(0, 255);
				t.rw = $urandom_range(0, 1);
				if (p == 3 && n == 20)
					hold_req = 1;
				send_tick(t, calm ? 0 : idle_len(), 1'b0, '0);
			end
			total += len;
			drain();
		end

		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("tb_run_step_clock_tracer: PASS");
		else
			$display("tb_run_step_clock_tracer: FAIL");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/rsct_pkg.sv
rtl/core/rsct_debounce.sv
rtl/core/rsct_pulse.sv
rtl/core/run_step_clock_tracer.sv
tb/sv/tb_run_step_clock_tracer.sv
